// ===== rtl/srsr_pkg.sv =====
package srsr_pkg;

   localparam int unsigned DEST_W   = 24;
   localparam int unsigned DELAY_W  = 8;
   localparam int unsigned WEIGHT_W = 32;
   localparam int unsigned CORES_W  = 8;
   localparam int unsigned DATA_W   = DEST_W + DELAY_W + WEIGHT_W;
   localparam int unsigned CSR_AW   = 4;
   localparam int unsigned CSR_DW   = 32;

   localparam logic [DELAY_W-1:0]  SYNC_DELAY = 8'hFE;
   localparam logic [DEST_W-1:0]   END_DEST   = 24'hFFFFFF;
   localparam logic [WEIGHT_W-1:0] END_WEIGHT = 32'h0;

   typedef enum logic [1:0] {
      REG_FIRST_NEURON = 2'd0,
      REG_NEURON_COUNT = 2'd1,
      REG_RING_CORES   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [DEST_W-1:0]  first_neuron;
      logic [DEST_W-1:0]  neuron_count;
      logic [CORES_W-1:0] ring_cores;
   } cfg_type;

   typedef struct packed {
      logic                to_ring;
      logic [DEST_W-1:0]   destination;
      logic [DELAY_W-1:0]  delay;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
   } result_type;

   typedef struct packed {
      logic [1:0]  count;
      result_type  first;
      result_type  second;
   } push_type;

endpackage

// ===== rtl/srsr_csr.sv =====
module srsr_csr
   import srsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_FIRST_NEURON: cfg_in.first_neuron = csr_pwdata[DEST_W-1:0];
            REG_NEURON_COUNT: cfg_in.neuron_count = csr_pwdata[DEST_W-1:0];
            REG_RING_CORES:   cfg_in.ring_cores   = csr_pwdata[CORES_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_FIRST_NEURON: csr_prdata = {{(CSR_DW-DEST_W){1'b0}}, cfg_ff.first_neuron};
         REG_NEURON_COUNT: csr_prdata = {{(CSR_DW-DEST_W){1'b0}}, cfg_ff.neuron_count};
         REG_RING_CORES:   csr_prdata = {{(CSR_DW-CORES_W){1'b0}}, cfg_ff.ring_cores};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_neuron <= '0;
         cfg_ff.neuron_count <= '0;
         cfg_ff.ring_cores   <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/srsr_route.sv =====
module srsr_route
   import srsr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_from_ring,
   input  logic [DEST_W-1:0]   req_destination,
   input  logic [DELAY_W-1:0]  req_delay,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  cfg_type             cfg,
   input  logic [1:0]          space,
   output push_type            push
);

   logic                in_valid_ff, in_valid_in;
   logic                from_ring_ff;
   logic [DEST_W-1:0]   dest_ff;
   logic [DELAY_W-1:0]  delay_ff;
   logic [WEIGHT_W-1:0] weight_ff;

   logic                local_done_ff, local_done_in;
   logic                ring_done_ff, ring_done_in;
   logic [CORES_W-1:0]  sync_seen_ff, sync_seen_in;

   logic                is_sync;
   logic [DEST_W:0]     top;
   logic                owned;
   logic                word_valid;
   logic                word_ring;
   logic                end_sync;
   logic [1:0]          need;
   logic                take;
   logic                load;
   logic [CORES_W-1:0]  target;
   result_type          word_res;
   result_type          end_res;

   always_comb begin
      is_sync = (delay_ff == SYNC_DELAY);
      top     = {1'b0, cfg.first_neuron} + {1'b0, cfg.neuron_count};
      owned   = ({1'b0, dest_ff} >= {1'b0, cfg.first_neuron}) && ({1'b0, dest_ff} < top);
      target  = cfg.ring_cores - 8'd1;

      word_valid = 1'b0;
      word_ring  = 1'b1;
      if (!from_ring_ff) begin
         if (is_sync) begin
            word_valid = 1'b1;
         end else if (owned) begin
            word_valid = 1'b1;
            word_ring  = 1'b0;
         end else begin
            word_valid = (dest_ff != '0);
         end
      end else if (!is_sync) begin
         word_valid = 1'b1;
         word_ring  = !owned;
      end

      local_done_in = local_done_ff;
      ring_done_in  = ring_done_ff;
      sync_seen_in  = sync_seen_ff;
      if (!from_ring_ff && is_sync) begin
         local_done_in = 1'b1;
      end
      if (from_ring_ff && is_sync) begin
         if (sync_seen_ff == target) begin
            ring_done_in = 1'b1;
         end else begin
            sync_seen_in = sync_seen_ff + 8'd1;
         end
      end
      end_sync = local_done_in & ring_done_in;
      if (end_sync) begin
         local_done_in = 1'b0;
         ring_done_in  = 1'b0;
         sync_seen_in  = '0;
      end

      need = {1'b0, word_valid} + {1'b0, end_sync};
      take = in_valid_ff && (need <= space);

      word_res.to_ring     = word_ring;
      word_res.destination = dest_ff;
      word_res.delay       = delay_ff;
      word_res.weight      = weight_ff;
      word_res.last        = !end_sync;

      end_res.to_ring     = 1'b0;
      end_res.destination = END_DEST;
      end_res.delay       = SYNC_DELAY;
      end_res.weight      = END_WEIGHT;
      end_res.last        = 1'b1;

      push.count  = take ? need : 2'd0;
      push.first  = word_valid ? word_res : end_res;
      push.second = end_res;
   end

   assign req_tready  = !in_valid_ff || take;
   assign load        = req_tvalid && req_tready;
   assign in_valid_in = load ? 1'b1 : (take ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         local_done_ff <= 1'b0;
         ring_done_ff  <= 1'b0;
         sync_seen_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (take) begin
            local_done_ff <= local_done_in;
            ring_done_ff  <= ring_done_in;
            sync_seen_ff  <= sync_seen_in;
         end
      end
      if (load) begin
         from_ring_ff <= req_from_ring;
         dest_ff      <= req_destination;
         delay_ff     <= req_delay;
         weight_ff    <= req_weight;
      end
   end

endmodule

// ===== rtl/srsr_outq.sv =====
module srsr_outq
   import srsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic [1:0] space,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type rsp_result
);

   result_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in;
   logic       wr;
   logic       pop;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_result = slot_ff[rd_ff];
   assign pop        = rsp_tvalid && rsp_tready;
   assign space      = 2'd2 - count_ff + {1'b0, pop};
   assign wr         = rd_ff ^ count_ff[0];
   assign count_in   = count_ff - {1'b0, pop} + push.count;
   assign rd_in      = rd_ff ^ pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
      end
      if (push.count != 2'd0) begin
         slot_ff[wr] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[!wr] <= push.second;
      end
   end

endmodule

// ===== rtl/spike_ring_synapse_router.sv =====
// channel   direction  handshake                 tdata (low bit up)            side bits
// req       in         req_tvalid / req_tready   destination, delay, weight    tuser from_ring
// rsp       out        rsp_tvalid / rsp_tready   destination, delay, weight    tuser to_ring, tlast
// csr       in         apb r/w, pready high      regs at 0x0, 0x4, 0x8         -
//
// one request per cycle while req_tready is high; it passes the input register, then the queue
// a local sync that closes the timestep gives two results, the sync word and then the end sync
// throughput is set by the two-entry queue draining one result a cycle while rsp_tready is high
// synchronous reset clears control state and sets config to its defaults, no clearing pass
// rsp stalls fill the queue, then the input register, then drop req_tready
module spike_ring_synapse_router
   import srsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // destination[23:0], delay[31:24], weight[63:32]
   input  logic              req_tuser,   // from_ring
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // destination[23:0], delay[31:24], weight[63:32]
   output logic              rsp_tuser,   // to_ring
   output logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type    cfg;
   push_type   push;
   logic [1:0] space;
   result_type rsp_result;

   srsr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   srsr_route u_route (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_from_ring   (req_tuser),
      .req_destination (req_tdata[DEST_W-1:0]),
      .req_delay       (req_tdata[DEST_W+DELAY_W-1:DEST_W]),
      .req_weight      (req_tdata[DATA_W-1:DEST_W+DELAY_W]),
      .cfg             (cfg),
      .space           (space),
      .push            (push)
   );

   srsr_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {rsp_result.weight, rsp_result.delay, rsp_result.destination};
   assign rsp_tuser = rsp_result.to_ring;
   assign rsp_tlast = rsp_result.last;

endmodule

// ===== rtl/srsr_checker.sv =====
module srsr_checker
   import srsr_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tuser,
   input logic              rsp_tlast
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // a sync to the local side is always the closing end sync
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && rsp_tdata[31:24] == SYNC_DELAY |->
         rsp_tlast && rsp_tdata[23:0] == END_DEST && rsp_tdata[63:32] == END_WEIGHT)
      else $error("malformed end sync");

   // a result that is not last has its end sync already queued
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("end sync missing after non-last result");

   // reset empties the result queue
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind spike_ring_synapse_router srsr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import srsr_pkg::*;

   localparam int WORD_TARGET = 2000;
   localparam int STALL_LIMIT = 3000;
   localparam int LONG_HOLD   = 300;

   typedef struct {
      bit            csr;
      reg_index_type idx;
      logic [23:0]   value;
      logic          from_ring;
      logic [23:0]   dest;
      logic [7:0]    dly;
      logic [31:0]   wt;
      int            typed;     // -1: routed by the predictor
      result_type    r0;
      result_type    r1;
   } plan_row_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;   // destination[23:0], delay[31:24], weight[63:32]
   logic              req_tuser;   // from_ring
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;   // destination[23:0], delay[31:24], weight[63:32]
   logic              rsp_tuser;   // to_ring
   logic              rsp_tlast;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   spike_ring_synapse_router dut (.*);

   // router shadow: registers and timestep state
   cfg_type      cfg_shadow;
   logic         step_local_done;
   logic         step_ring_done;
   logic [7:0]   step_syncs;

   result_type   words_due[$];
   plan_row_type plan[$];
   int           fault_count;
   int           words_sent;
   int           quiet_cycles;
   bit           req_gaps;
   bit           rsp_gaps;
   bit           hold_rsp;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic bit owned(input logic [23:0] dest);
      logic [24:0] top;
      top = {1'b0, cfg_shadow.first_neuron} + {1'b0, cfg_shadow.neuron_count};
      return dest >= cfg_shadow.first_neuron && {1'b0, dest} < top;
   endfunction

   function automatic void route_word(input logic fr, input logic [23:0] dest,
                                      input logic [7:0] dly, input logic [31:0] wt,
                                      ref result_type routed[$]);
      if (!fr) begin
         if (dly == SYNC_DELAY) begin
            step_local_done = 1'b1;
            routed.push_back('{1'b1, dest, dly, wt, 1'b0});
         end else if (owned(dest)) begin
            routed.push_back('{1'b0, dest, dly, wt, 1'b0});
         end else if (dest != '0) begin
            routed.push_back('{1'b1, dest, dly, wt, 1'b0});
         end
      end else begin
         if (dly == SYNC_DELAY) begin
            if (step_syncs == 8'(cfg_shadow.ring_cores - 8'd1)) begin
               step_ring_done = 1'b1;
            end else begin
               step_syncs = step_syncs + 8'd1;
            end
         end else if (owned(dest)) begin
            routed.push_back('{1'b0, dest, dly, wt, 1'b0});
         end else begin
            routed.push_back('{1'b1, dest, dly, wt, 1'b0});
         end
      end
      if (step_local_done && step_ring_done) begin
         routed.push_back('{1'b0, END_DEST, SYNC_DELAY, END_WEIGHT, 1'b0});
         step_local_done = 1'b0;
         step_ring_done = 1'b0;
         step_syncs = '0;
      end
      if (routed.size() > 0) routed[routed.size()-1].last = 1'b1;
   endfunction

   function automatic plan_row_type word_row(input logic fr, input logic [23:0] dest,
                                             input logic [7:0] dly, input logic [31:0] wt,
                                             input int typed, input result_type r0,
                                             input result_type r1);
      plan_row_type row;
      row.csr = 1'b0;
      row.idx = REG_FIRST_NEURON;
      row.value = '0;
      row.from_ring = fr;
      row.dest = dest;
      row.dly = dly;
      row.wt = wt;
      row.typed = typed;
      row.r0 = r0;
      row.r1 = r1;
      return row;
   endfunction

   function automatic plan_row_type csr_row(input reg_index_type idx,
                                            input logic [23:0] value);
      plan_row_type row;
      row = word_row(1'b0, '0, '0, '0, -1, '0, '0);
      row.csr = 1'b1;
      row.idx = idx;
      row.value = value;
      return row;
   endfunction

   function automatic logic [23:0] pick_dest();
      logic [23:0] lo;
      logic [23:0] hi;
      lo = cfg_shadow.first_neuron;
      hi = lo + cfg_shadow.neuron_count;
      case ($urandom_range(0, 7))
         0: return lo;
         1: return lo - 24'd1;
         2: return hi - 24'd1;
         3: return hi;
         4: return '0;
         5: return END_DEST;
         6: return lo + 24'($urandom_range(0, 15));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic plan_row_type random_word(input bit noise);
      logic [7:0] dly;
      dly = 8'($urandom_range(0, 255));
      if (noise && $urandom_range(0, 3) == 0) dly = SYNC_DELAY;
      else if (!noise && dly == SYNC_DELAY) dly = 8'hFF;
      return word_row(1'($urandom_range(0, 1)), pick_dest(), dly, $urandom, -1, '0, '0);
   endfunction

   function automatic plan_row_type sync_word(input logic fr);
      return word_row(fr, 24'($urandom), SYNC_DELAY, $urandom, -1, '0, '0);
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         fault_count++;
         $display("%0t %s mismatch: expected %h, got %h", $time, field, want, got);
      end
   endfunction

   task automatic send_word(input plan_row_type row);
      result_type routed[$];
      int gap;
      gap = req_gaps ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= row.from_ring;
      req_tdata <= {row.wt, row.dly, row.dest};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      route_word(row.from_ring, row.dest, row.dly, row.wt, routed);
      if (row.typed < 0) begin
         foreach (routed[i]) words_due.push_back(routed[i]);
      end else begin
         if (row.typed > 0) words_due.push_back(row.r0);
         if (row.typed > 1) words_due.push_back(row.r1);
      end
   endtask

   // block idle: every result back, then room for words that give none
   task automatic settle_ring();
      req_tvalid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [23:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {8'h00, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_FIRST_NEURON: cfg_shadow.first_neuron = value;
         REG_NEURON_COUNT: cfg_shadow.neuron_count = value;
         default:          cfg_shadow.ring_cores = value[7:0];
      endcase
   endtask

   task automatic run_timestep(input bit broken);
      plan_row_type seq[$];
      plan_row_type tmp;
      logic [7:0] missing;
      int n_words;
      int n_ring;
      int i;
      int j;
      n_words = $urandom_range(0, 12);
      missing = cfg_shadow.ring_cores - 8'd1 - step_syncs;
      n_ring = step_ring_done ? 0 : int'(missing) + 1;
      for (i = 0; i < n_words; i++) seq.push_back(random_word(1'b0));
      for (i = 0; i < n_ring; i++) seq.push_back(sync_word(1'b1));
      seq.push_back(sync_word(1'b0));
      if (broken) begin
         case ($urandom_range(0, 2))
            0: seq.delete(seq.size() - 1);
            1: if (n_ring > 0) seq.delete(n_words);
            default: seq.push_back(sync_word(1'($urandom_range(0, 1))));
         endcase
      end
      for (i = seq.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = seq[i];
         seq[i] = seq[j];
         seq[j] = tmp;
      end
      foreach (seq[k]) send_word(seq[k]);
   endtask

   // result check
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (words_due.size() == 0) begin
            fault_count++;
            $display("%0t unexpected result: expected none, got %h %b %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = words_due.pop_front();
            check_field("to_ring", 32'(want.to_ring), 32'(rsp_tuser));
            check_field("destination", 32'(want.destination), 32'(rsp_tdata[23:0]));
            check_field("delay", 32'(want.delay), 32'(rsp_tdata[31:24]));
            check_field("weight", want.weight, rsp_tdata[63:32]);
            check_field("last", 32'(want.last), 32'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = rsp_gaps ? $urandom_range(0, 11) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // request side
   initial begin
      logic [23:0] first_val;
      logic [23:0] count_val;
      logic [7:0]  cores_val;
      int phase;
      int steps;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      fault_count = 0;
      words_sent = 0;
      quiet_cycles = 0;
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      hold_rsp = 1'b0;
      cfg_shadow = '{first_neuron: '0, neuron_count: '0, ring_cores: 8'd1};
      step_local_done = 1'b0;
      step_ring_done = 1'b0;
      step_syncs = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // after reset nothing is owned and one core closes the ring
      plan.push_back(word_row(1'b0, 24'h000000, 8'h00, 32'h0, 0, '0, '0));
      plan.push_back(word_row(1'b0, 24'hFFFFFF, 8'hFF, 32'hFFFFFFFF, 1,
                              '{1'b1, 24'hFFFFFF, 8'hFF, 32'hFFFFFFFF, 1'b1}, '0));
      plan.push_back(word_row(1'b1, 24'h000000, 8'h00, 32'h0, 1,
                              '{1'b1, 24'h000000, 8'h00, 32'h0, 1'b1}, '0));
      plan.push_back(word_row(1'b1, 24'h123456, SYNC_DELAY, 32'h5A5A5A5A, 0, '0, '0));
      plan.push_back(word_row(1'b0, 24'h000005, SYNC_DELAY, 32'hDEADBEEF, 2,
                              '{1'b1, 24'h000005, SYNC_DELAY, 32'hDEADBEEF, 1'b0},
                              '{1'b0, END_DEST, SYNC_DELAY, END_WEIGHT, 1'b1}));
      plan.push_back(word_row(1'b0, 24'hABCDEF, SYNC_DELAY, 32'h0, 1,
                              '{1'b1, 24'hABCDEF, SYNC_DELAY, 32'h0, 1'b1}, '0));
      plan.push_back(word_row(1'b0, 24'h654321, SYNC_DELAY, 32'h80000001, 1,
                              '{1'b1, 24'h654321, SYNC_DELAY, 32'h80000001, 1'b1}, '0));
      plan.push_back(word_row(1'b1, 24'h000000, SYNC_DELAY, 32'h0, 1,
                              '{1'b0, END_DEST, SYNC_DELAY, END_WEIGHT, 1'b1}, '0));
      plan.push_back(csr_row(REG_FIRST_NEURON, 24'h000100));
      plan.push_back(csr_row(REG_NEURON_COUNT, 24'h000010));
      plan.push_back(csr_row(REG_RING_CORES, 24'h000003));
      plan.push_back(word_row(1'b0, 24'h000100, 8'h03, 32'h3F800000, -1, '0, '0));
      plan.push_back(word_row(1'b0, 24'h00010F, 8'h00, 32'hBF800000, -1, '0, '0));
      plan.push_back(word_row(1'b0, 24'h000110, 8'h01, 32'h00000001, -1, '0, '0));
      plan.push_back(word_row(1'b0, 24'h0000FF, 8'hFD, 32'h7FFFFFFF, -1, '0, '0));
      plan.push_back(word_row(1'b1, 24'h000100, 8'hFF, 32'hFFFF0000, -1, '0, '0));
      plan.push_back(word_row(1'b1, 24'h000110, 8'h01, 32'h0000FFFF, -1, '0, '0));
      plan.push_back(word_row(1'b1, 24'h000000, SYNC_DELAY, 32'h11111111, -1, '0, '0));
      plan.push_back(word_row(1'b0, 24'h000107, SYNC_DELAY, 32'h22222222, -1, '0, '0));
      plan.push_back(word_row(1'b1, 24'hFFFFFF, SYNC_DELAY, 32'h33333333, -1, '0, '0));
      plan.push_back(word_row(1'b1, 24'h000105, 8'h07, 32'h44444444, -1, '0, '0));
      plan.push_back(word_row(1'b1, 24'h000001, SYNC_DELAY, 32'h55555555, -1, '0, '0));
      plan.push_back(csr_row(REG_FIRST_NEURON, 24'h000000));
      plan.push_back(csr_row(REG_NEURON_COUNT, 24'h000005));
      plan.push_back(csr_row(REG_RING_CORES, 24'h000002));
      plan.push_back(word_row(1'b0, 24'h000000, 8'h02, 32'h66666666, -1, '0, '0));
      plan.push_back(word_row(1'b1, 24'h000000, 8'h09, 32'h77777777, -1, '0, '0));
      plan.push_back(csr_row(REG_FIRST_NEURON, 24'hFFFFFF));
      plan.push_back(csr_row(REG_NEURON_COUNT, 24'hFFFFFF));
      plan.push_back(csr_row(REG_RING_CORES, 24'h0000FF));
      plan.push_back(word_row(1'b0, 24'hFFFFFF, 8'h00, 32'h88888888, -1, '0, '0));
      plan.push_back(word_row(1'b1, 24'hFFFFFE, 8'hFF, 32'h99999999, -1, '0, '0));
      plan.push_back(word_row(1'b1, 24'h000042, SYNC_DELAY, 32'hAAAAAAAA, -1, '0, '0));
      plan.push_back(csr_row(REG_RING_CORES, 24'h000000));
      plan.push_back(word_row(1'b0, 24'h000042, SYNC_DELAY, 32'hBBBBBBBB, -1, '0, '0));

      foreach (plan[i]) begin
         if (plan[i].csr) begin
            settle_ring();
            write_csr(plan[i].idx, plan[i].value);
         end else begin
            send_word(plan[i]);
         end
      end

      phase = 0;
      while (words_sent < WORD_TARGET) begin
         settle_ring();
         req_gaps = $urandom_range(0, 2) != 0;
         rsp_gaps = $urandom_range(0, 2) != 0;
         case ($urandom_range(0, 5))
            0: first_val = '0;
            1: first_val = 24'hFFFFFF;
            2: first_val = 24'($urandom);
            default: first_val = 24'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 5))
            0: count_val = '0;
            1: count_val = 24'hFFFFFF;
            2: count_val = 24'($urandom);
            default: count_val = 24'($urandom_range(1, 64));
         endcase
         case ($urandom_range(0, 15))
            0: cores_val = 8'd0;
            1: cores_val = 8'd255;
            default: cores_val = 8'($urandom_range(1, 4));
         endcase
         // a leftover sync count above the new target forces a full wrap
         if (phase == 0) cores_val = 8'd1;
         write_csr(REG_FIRST_NEURON, first_val);
         write_csr(REG_NEURON_COUNT, count_val);
         write_csr(REG_RING_CORES, {16'h0000, cores_val});
         steps = (cores_val == 8'd0 || cores_val == 8'd255) ? 1 : $urandom_range(1, 4);
         if (phase == 3) begin
            req_gaps = 1'b0;
            hold_rsp = 1'b1;
            steps = 4;
         end
         repeat (steps) run_timestep($urandom_range(0, 6) == 0);
         repeat ($urandom_range(0, 3)) send_word(random_word(1'b1));
         phase++;
      end

      req_tvalid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fault_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/srsr_pkg.sv
rtl/srsr_csr.sv
rtl/srsr_route.sv
rtl/srsr_outq.sv
rtl/spike_ring_synapse_router.sv
rtl/srsr_checker.sv
tb/testbench.sv
